// ===== hdl/assert_macros.svh =====
// Assertion macros used by the responder RTL.
// Depends on nothing; callers provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/jcr_pkg.sv =====
// Types, line symbol codes and reply microprogram for the joybus responder.
// No dependencies.
package jcr_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_symbol;
        logic [7:0] button_byte_a;
        logic [7:0] button_byte_b;
        logic [7:0] stick_x;
        logic [7:0] stick_y;
        logic [7:0] cstick_x;
        logic [7:0] cstick_y;
        logic [7:0] trigger_left;
        logic [7:0] trigger_right;
    } in_beat_t;

    typedef struct packed {
        logic [5:0] tx_symbol;
        logic       last_of_reply;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_STOP
    } state_t;

    // Line symbols, two data bits each
    localparam logic [5:0] SYM_00   = 6'h04;
    localparam logic [5:0] SYM_01   = 6'h34;
    localparam logic [5:0] SYM_10   = 6'h07;
    localparam logic [5:0] SYM_11   = 6'h37;
    localparam logic [5:0] SYM_STOP = 6'h3F;

    localparam logic       CMD_SYMBOL = 1'b0;
    localparam logic       CMD_LOAD   = 1'b1;

    localparam logic [7:0] ORIGIN_LOW = 8'h41;
    localparam logic [7:0] POLL_CMD   = 8'h40;
    localparam logic [7:0] POLL_FMT   = 8'h03;

    localparam int         REPORT_BYTES = 8;
    localparam int         PC_W         = 5;
    localparam int         ROM_DEPTH    = 21;

    // Entry points of the three reply programs
    localparam logic [PC_W-1:0] ENTRY_PROBE  = 5'd0;
    localparam logic [PC_W-1:0] ENTRY_ORIGIN = 5'd3;
    localparam logic [PC_W-1:0] ENTRY_POLL   = 5'd13;

    // One control word emits one byte: a constant or a report byte.
    typedef struct packed {
        logic       from_report;
        logic [7:0] data;
        logic [2:0] idx;
        logic       last;
    } uword_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] addr);
        uword_t w;
        w = '{from_report: 1'b0, data: 8'h00, idx: 3'd0, last: 1'b0};
        unique case (addr)
            // probe: 09 00 03
            5'd0:  w.data = 8'h09;
            5'd1:  w.data = 8'h00;
            5'd2:  begin w.data = 8'h03; w.last = 1'b1; end
            // origins: 00 80 80 80 80 80 00 00 00 00
            5'd3:  w.data = 8'h00;
            5'd4:  w.data = 8'h80;
            5'd5:  w.data = 8'h80;
            5'd6:  w.data = 8'h80;
            5'd7:  w.data = 8'h80;
            5'd8:  w.data = 8'h80;
            5'd9:  w.data = 8'h00;
            5'd10: w.data = 8'h00;
            5'd11: w.data = 8'h00;
            5'd12: begin w.data = 8'h00; w.last = 1'b1; end
            // poll: stored report bytes 0..7
            5'd13: begin w.from_report = 1'b1; w.idx = 3'd0; end
            5'd14: begin w.from_report = 1'b1; w.idx = 3'd1; end
            5'd15: begin w.from_report = 1'b1; w.idx = 3'd2; end
            5'd16: begin w.from_report = 1'b1; w.idx = 3'd3; end
            5'd17: begin w.from_report = 1'b1; w.idx = 3'd4; end
            5'd18: begin w.from_report = 1'b1; w.idx = 3'd5; end
            5'd19: begin w.from_report = 1'b1; w.idx = 3'd6; end
            5'd20: begin w.from_report = 1'b1; w.idx = 3'd7; w.last = 1'b1; end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

    function automatic logic [5:0] pair_sym(input logic [1:0] pair);
        logic [5:0] s;
        unique case (pair)
            2'b00: s = SYM_00;
            2'b01: s = SYM_01;
            2'b10: s = SYM_10;
            2'b11: s = SYM_11;
            default: s = SYM_00;
        endcase
        return s;
    endfunction

    // Neutral report loaded at reset
    function automatic logic [7:0] neutral_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd1, 3'd2, 3'd3, 3'd4, 3'd5: b = 8'h80;
            default:                      b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/joybus_controller_responder.sv =====
// Joybus controller responder: line symbol decode and microcoded reply sender.
// Depends on jcr_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one beat per line symbol
//   (cmd 0) or one report load (cmd 1). Output channel (out_valid/out_ready/
//   out_data) carries reply symbols, the final stop beat flagged with
//   last_of_reply.
//   A stop symbol that triggers a reply starts a ROM program: one control word
//   per reply byte, four symbols per word, then a stop symbol. Replies are 13,
//   33 or 41 beats; accepting the stop moves the sequencer into its data
//   state, which loads the first beat into the output register, and one beat
//   follows per cycle while out_ready is high. in_ready is low until the stop
//   beat has been loaded into the output register; every other item is taken
//   at once. Throughput is set by the sequencer, one symbol per unstalled cycle.
//   A stalled receiver holds the output register and freezes the sequencer.
//   Reset clears the command buffer and echo flag and loads the neutral report
//   (00 80 80 80 80 80 00 00).
module joybus_controller_responder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  jcr_pkg::in_beat_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output jcr_pkg::out_beat_t out_data
);

    `include "assert_macros.svh"

    jcr_pkg::state_t              state_reg, state_next;
    logic [jcr_pkg::PC_W-1:0]     pc_reg, pc_next;
    logic [1:0]                   pair_reg, pair_next;
    logic [31:0]                  shift_reg, shift_next;
    logic                         echo_pending_reg, echo_pending_next;
    logic [7:0]                   report_reg [jcr_pkg::REPORT_BYTES];
    logic [7:0]                   report_next [jcr_pkg::REPORT_BYTES];
    logic                         out_valid_reg, out_valid_next;
    jcr_pkg::out_beat_t           out_data_reg, out_data_next;

    jcr_pkg::uword_t              uw;
    logic [7:0]                   byte_sel;
    logic [1:0]                   pair_bits;
    logic                         in_take;
    logic                         advance;
    logic                         rx_is_stop;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= jcr_pkg::ST_IDLE;
            pc_reg           <= '0;
            pair_reg         <= '0;
            shift_reg        <= '0;
            echo_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < jcr_pkg::REPORT_BYTES; i++)
            begin
                report_reg[i] <= jcr_pkg::neutral_byte(3'(i));
            end
        end
        else
        begin
            state_reg        <= state_next;
            pc_reg           <= pc_next;
            pair_reg         <= pair_next;
            shift_reg        <= shift_next;
            echo_pending_reg <= echo_pending_next;
            out_valid_reg    <= out_valid_next;
            report_reg       <= report_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        uw       = jcr_pkg::ucode(pc_reg);
        byte_sel = uw.from_report ? report_reg[uw.idx] : uw.data;
        // most significant pair goes out first
        unique case (pair_reg)
            2'd0: pair_bits = byte_sel[7:6];
            2'd1: pair_bits = byte_sel[5:4];
            2'd2: pair_bits = byte_sel[3:2];
            2'd3: pair_bits = byte_sel[1:0];
            default: pair_bits = byte_sel[1:0];
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        pc_next           = pc_reg;
        pair_next         = pair_reg;
        shift_next        = shift_reg;
        echo_pending_next = echo_pending_reg;
        report_next       = report_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;

        in_ready   = (state_reg == jcr_pkg::ST_IDLE);
        in_take    = in_valid && in_ready;
        advance    = !out_valid_reg || out_ready;
        rx_is_stop = (in_data.rx_symbol == {2'b00, jcr_pkg::SYM_STOP});

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            jcr_pkg::ST_IDLE:
            begin
                if (in_take && in_data.cmd == jcr_pkg::CMD_LOAD)
                begin
                    report_next[0] = in_data.button_byte_a;
                    report_next[1] = in_data.button_byte_b;
                    report_next[2] = in_data.stick_x;
                    report_next[3] = in_data.stick_y;
                    report_next[4] = in_data.cstick_x;
                    report_next[5] = in_data.cstick_y;
                    report_next[6] = in_data.trigger_left;
                    report_next[7] = in_data.trigger_right;
                end
                else if (in_take && rx_is_stop)
                begin
                    shift_next = '0;
                    pair_next  = '0;
                    if (echo_pending_reg)
                    begin
                        echo_pending_next = 1'b0;
                    end
                    else if (shift_reg[29:0] == '0)
                    begin
                        pc_next           = jcr_pkg::ENTRY_PROBE;
                        state_next        = jcr_pkg::ST_DATA;
                        echo_pending_next = 1'b1;
                    end
                    else if (shift_reg[7:0] == jcr_pkg::ORIGIN_LOW)
                    begin
                        pc_next           = jcr_pkg::ENTRY_ORIGIN;
                        state_next        = jcr_pkg::ST_DATA;
                        echo_pending_next = 1'b1;
                    end
                    else if (shift_reg[23:16] == jcr_pkg::POLL_CMD
                             && shift_reg[15:8] == jcr_pkg::POLL_FMT)
                    begin
                        pc_next           = jcr_pkg::ENTRY_POLL;
                        state_next        = jcr_pkg::ST_DATA;
                        echo_pending_next = 1'b1;
                    end
                end
                else if (in_take)
                begin
                    priority if (in_data.rx_symbol == {2'b00, jcr_pkg::SYM_00})
                        shift_next = {shift_reg[29:0], 2'b00};
                    else if (in_data.rx_symbol == {2'b00, jcr_pkg::SYM_01})
                        shift_next = {shift_reg[29:0], 2'b01};
                    else if (in_data.rx_symbol == {2'b00, jcr_pkg::SYM_10})
                        shift_next = {shift_reg[29:0], 2'b10};
                    else if (in_data.rx_symbol == {2'b00, jcr_pkg::SYM_11})
                        shift_next = {shift_reg[29:0], 2'b11};
                    else
                        shift_next = {shift_reg[29:0], 2'b00};
                end
            end

            jcr_pkg::ST_DATA:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{tx_symbol: jcr_pkg::pair_sym(pair_bits),
                                       last_of_reply: 1'b0};
                    pair_next      = pair_reg + 2'd1;
                    if (pair_reg == 2'd3)
                    begin
                        if (uw.last)
                            state_next = jcr_pkg::ST_STOP;
                        else
                            pc_next = pc_reg + 5'd1;
                    end
                end
            end

            jcr_pkg::ST_STOP:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{tx_symbol: jcr_pkg::SYM_STOP, last_of_reply: 1'b1};
                    state_next     = jcr_pkg::ST_IDLE;
                end
            end

            default: state_next = jcr_pkg::ST_IDLE;
        endcase
    end

    `ASSERT_SAME(a_last_is_stop, out_valid && out_data.last_of_reply, out_data.tx_symbol == jcr_pkg::SYM_STOP)
    `ASSERT_SAME(a_data_not_stop, out_valid && !out_data.last_of_reply, out_data.tx_symbol != jcr_pkg::SYM_STOP)
    `ASSERT_SAME(a_pc_in_rom, state_reg == jcr_pkg::ST_DATA, pc_reg < 5'(jcr_pkg::ROM_DEPTH))
    `ASSERT_NEXT(a_echo_swallows, in_take && !in_data.cmd && rx_is_stop && echo_pending_reg, !echo_pending_reg && state_reg == jcr_pkg::ST_IDLE)
    `ASSERT_NEXT(a_stall_freezes, state_reg != jcr_pkg::ST_IDLE && out_valid_reg && !out_ready, $stable(pc_reg) && $stable(pair_reg))

endmodule
